// ===== rtl/hrke_pkg.sv =====
// ----------------------------------------------------------------------------
// hrke_pkg: shared types and constants
// Event slot layout, key lane results and per-report state of the HID report
// to key event converter.
// ----------------------------------------------------------------------------
package hrke_pkg;

   localparam int KEY_SLOTS  = 6;
   localparam int NUM_MODS   = 8;
   localparam int NUM_EVENTS = NUM_MODS + 2 * KEY_SLOTS;
   localparam int EVT_IDX_W  = $clog2(NUM_EVENTS);
   localparam int CSR_ADDR_W = 1;

   // Input item kinds
   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_DELAY  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_PERIOD = 1'b1;

   // Usage of the left control key; modifier bit b maps to MOD_USAGE_BASE + b
   localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;

   // Emission order of the modifier bits: LShift, RShift, LCtrl, RCtrl, ...
   localparam logic [2:0] MOD_ORDER [NUM_MODS] = '{
      3'd1, 3'd5, 3'd0, 3'd4, 3'd2, 3'd6, 3'd3, 3'd7
   };

   typedef logic [KEY_SLOTS-1:0][7:0] key_set_type;

   typedef struct packed {
      logic is_new;   // key present now, absent from the previous report
      logic is_gone;  // previous key absent from the current report
   } lane_result_type;

   // One item's worth of events, emitted lowest set mask bit first
   typedef struct packed {
      logic [NUM_EVENTS-1:0]      mask;
      logic [NUM_EVENTS-1:0][7:0] code;
      logic [NUM_EVENTS-1:0]      pressed;
   } job_type;

   typedef struct packed {
      logic [7:0]  prev_mods;
      key_set_type prev_keys;
      logic [7:0]  repeat_key;
      logic [15:0] countdown;
   } kbd_state_type;

endpackage

// ===== rtl/hrke_req_if.sv =====
// ----------------------------------------------------------------------------
// hrke_req_if: input channel
// Report or tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrke_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] modifier_bits;
   logic [7:0] slot_0;
   logic [7:0] slot_1;
   logic [7:0] slot_2;
   logic [7:0] slot_3;
   logic [7:0] slot_4;
   logic [7:0] slot_5;

   modport source (
      output valid, cmd, modifier_bits, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5,
      input  ready
   );
   modport sink (
      input  valid, cmd, modifier_bits, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5,
      output ready
   );
endinterface

// ===== rtl/hrke_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hrke_rsp_if: result channel
// Key events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrke_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;
   logic       pressed;
   logic       last;

   modport source (output valid, key_code, pressed, last, input ready);
   modport sink   (input valid, key_code, pressed, last, output ready);
endinterface

// ===== rtl/hrke_csr_if.sv =====
// ----------------------------------------------------------------------------
// hrke_csr_if: configuration write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrke_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  addr;
   logic [15:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/hrke_slot_lane.sv =====
// ----------------------------------------------------------------------------
// hrke_slot_lane: per-slot key comparison
// Judges one slot of the new report against the previous key set, and the
// same slot of the previous report against the new key set.
// ----------------------------------------------------------------------------
module hrke_slot_lane
   import hrke_pkg::*;
(
   input  logic [7:0]      key,
   input  logic [7:0]      prev_key,
   input  key_set_type     keys,
   input  key_set_type     prev_keys,
   output lane_result_type result
);

   logic in_prev;
   logic in_curr;

   always_comb begin
      in_prev = 1'b0;
      in_curr = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (prev_keys[i] == key) begin
            in_prev = 1'b1;
         end
         if (keys[i] == prev_key) begin
            in_curr = 1'b1;
         end
      end
      result.is_new  = (key != 8'd0) && !in_prev;
      result.is_gone = (prev_key != 8'd0) && !in_curr;
   end

endmodule

// ===== rtl/hrke_event_merge.sv =====
// ----------------------------------------------------------------------------
// hrke_event_merge: event list and next state
// Combines the lane results into the ordered event list of one item and
// works out the next keyboard and repeat state.
// ----------------------------------------------------------------------------
module hrke_event_merge
   import hrke_pkg::*;
(
   input  logic                           cmd,
   input  logic [7:0]                     mods,
   input  key_set_type                    keys,
   input  lane_result_type [KEY_SLOTS-1:0] lanes,
   input  kbd_state_type                  state,
   input  logic [15:0]                    repeat_delay,
   input  logic [15:0]                    repeat_period,
   output job_type                        job,
   output kbd_state_type                  next_state
);

   logic [7:0]  mod_diff;
   logic [7:0]  rk_after_press;
   logic        any_new;
   logic        rk_released;
   logic [15:0] cd_dec;
   logic [2:0]  bit_sel;

   always_comb begin
      job        = '0;
      next_state = state;
      mod_diff   = mods ^ state.prev_mods;
      rk_after_press = state.repeat_key;
      any_new     = 1'b0;
      rk_released = 1'b0;
      cd_dec      = (state.countdown != 16'd0) ? state.countdown - 16'd1 : state.countdown;
      bit_sel     = 3'd0;

      if (cmd == CMD_TICK) begin
         // Count down the live repeat key; fire and reload at zero
         if (state.repeat_key != 8'd0) begin
            if (cd_dec == 16'd0) begin
               job.mask[0]          = 1'b1;
               job.code[0]          = state.repeat_key;
               job.pressed[0]       = 1'b1;
               next_state.countdown = repeat_period;
            end else begin
               next_state.countdown = cd_dec;
            end
         end
      end else begin
         for (int e = 0; e < NUM_MODS; e++) begin
            bit_sel        = MOD_ORDER[e];
            job.mask[e]    = mod_diff[bit_sel];
            job.code[e]    = MOD_USAGE_BASE + {5'd0, bit_sel};
            job.pressed[e] = mods[bit_sel];
         end
         for (int i = 0; i < KEY_SLOTS; i++) begin
            job.mask[NUM_MODS + i]    = lanes[i].is_new;
            job.code[NUM_MODS + i]    = keys[i];
            job.pressed[NUM_MODS + i] = 1'b1;
            if (lanes[i].is_new) begin
               any_new        = 1'b1;
               rk_after_press = keys[i];
            end
         end
         for (int i = 0; i < KEY_SLOTS; i++) begin
            job.mask[NUM_MODS + KEY_SLOTS + i]    = lanes[i].is_gone;
            job.code[NUM_MODS + KEY_SLOTS + i]    = state.prev_keys[i];
            job.pressed[NUM_MODS + KEY_SLOTS + i] = 1'b0;
         end
         for (int i = 0; i < KEY_SLOTS; i++) begin
            if (lanes[i].is_gone && (state.prev_keys[i] == rk_after_press)) begin
               rk_released = 1'b1;
            end
         end
         next_state.prev_mods  = mods;
         next_state.prev_keys  = keys;
         next_state.repeat_key = rk_released ? 8'd0 : rk_after_press;
         if (any_new) begin
            next_state.countdown = repeat_delay;
         end
      end
   end

endmodule

// ===== rtl/hrke_event_emitter.sv =====
// ----------------------------------------------------------------------------
// hrke_event_emitter: event serialiser
// Holds the events of one item and sends them one per cycle, while the
// receiver takes them, through a registered output stage.
// ----------------------------------------------------------------------------
module hrke_event_emitter
   import hrke_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  job_type        job,
   output logic           can_load,
   hrke_rsp_if.source     rsp
);

   job_type               job_ff, job_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            key_code_ff, key_code_in;
   logic                  pressed_ff, pressed_in;
   logic                  last_ff, last_in;

   logic [NUM_EVENTS-1:0] pick;
   logic [NUM_EVENTS-1:0] rest;
   logic [EVT_IDX_W-1:0]  pick_idx;
   logic                  out_free;
   logic                  job_busy;

   always_comb begin
      pick     = job_ff.mask & (~job_ff.mask + 1'b1);
      rest     = job_ff.mask & ~pick;
      pick_idx = '0;
      for (int e = 0; e < NUM_EVENTS; e++) begin
         if (pick[e]) begin
            pick_idx = EVT_IDX_W'(e);
         end
      end
      out_free = !rsp_valid_ff || rsp.ready;
      job_busy = (job_ff.mask != '0);
      // Take a new item once the held events are gone or the last one leaves now
      can_load = !job_busy || (out_free && (rest == '0));

      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff;
      key_code_in  = key_code_ff;
      pressed_in   = pressed_ff;
      last_in      = last_ff;

      if (out_free) begin
         rsp_valid_in = job_busy;
         key_code_in  = job_ff.code[pick_idx];
         pressed_in   = job_ff.pressed[pick_idx];
         last_in      = (rest == '0);
         job_in.mask  = rest;
      end
      if (load) begin
         job_in = job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.mask  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_ff.mask  <= job_in.mask;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff.code    <= job_in.code;
      job_ff.pressed <= job_in.pressed;
      key_code_ff    <= key_code_in;
      pressed_ff     <= pressed_in;
      last_ff        <= last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.key_code = key_code_ff;
   assign rsp.pressed  = pressed_ff;
   assign rsp.last     = last_ff;

endmodule

// ===== rtl/hid_report_to_key_events.sv =====
// ----------------------------------------------------------------------------
// hid_report_to_key_events: HID boot-keyboard report to key events
// Diffs keyboard reports against the previous one and adds typematic repeat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries either a keyboard report (cmd = report: modifier byte and
//   six key slots) or a one millisecond tick (cmd = tick, other fields
//   ignored). rsp_ch returns key events (usage, pressed, last), with last
//   set on the final event caused by one input item; an item that causes no
//   event returns nothing. csr_ch writes the repeat delay (index 0) and the
//   repeat period (index 1); it is ready outside reset, and the user is to
//   write it only while idle (the block does not enforce this). Timing:
//   each slot has its own comparison lane; the lanes and the merge run in
//   the accept cycle and state is updated at once. The events of an item
//   then leave one per cycle while the receiver is ready; each passes
//   through the job register and then the output register before it can
//   transfer out. An item carries up to 20 events; the next item is taken
//   in the cycle its predecessor's last event moves into the output
//   register, so items follow back to back; an item with no events does
//   not hold up the next. The event output sets this one-per-cycle rate.
//   Reset clears the previous report, the repeat key and countdown, loads
//   delay 500 and period 100, and holds req_ch and csr_ch not ready. A
//   stalled receiver holds the output register and the pending events;
//   req_ch then stays not ready until the last pending event can move on.
// ----------------------------------------------------------------------------
module hid_report_to_key_events
   import hrke_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hrke_req_if.sink   req_ch,
   hrke_rsp_if.source rsp_ch,
   hrke_csr_if.sink   csr_ch
);

   kbd_state_type                   state_ff, state_in;
   logic [15:0]                     delay_ff, delay_in;
   logic [15:0]                     period_ff, period_in;

   key_set_type                     keys;
   lane_result_type [KEY_SLOTS-1:0] lanes;
   job_type                         job;
   kbd_state_type                   merged_state;
   logic                            req_fire;
   logic                            can_load;

   // Gather the slots of the incoming report
   assign keys[0] = req_ch.slot_0;
   assign keys[1] = req_ch.slot_1;
   assign keys[2] = req_ch.slot_2;
   assign keys[3] = req_ch.slot_3;
   assign keys[4] = req_ch.slot_4;
   assign keys[5] = req_ch.slot_5;

   // One comparison lane per key slot
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
      hrke_slot_lane u_lane (
         .key       (keys[i]),
         .prev_key  (state_ff.prev_keys[i]),
         .keys      (keys),
         .prev_keys (state_ff.prev_keys),
         .result    (lanes[i])
      );
   end

   // Merge the lane results into the ordered event list
   hrke_event_merge u_merge (
      .cmd           (req_ch.cmd),
      .mods          (req_ch.modifier_bits),
      .keys          (keys),
      .lanes         (lanes),
      .state         (state_ff),
      .repeat_delay  (delay_ff),
      .repeat_period (period_ff),
      .job           (job),
      .next_state    (merged_state)
   );

   assign req_ch.ready = can_load && !reset;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = !reset;

   // Advance the keyboard state on every item transfer
   always_comb begin
      state_in  = req_fire ? merged_state : state_ff;
      delay_in  = delay_ff;
      period_in = period_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.addr)
            REG_REPEAT_DELAY:  delay_in  = csr_ch.data;
            REG_REPEAT_PERIOD: period_in = csr_ch.data;
            default:           delay_in  = delay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         delay_ff  <= 16'd500;
         period_ff <= 16'd100;
      end else begin
         state_ff  <= state_in;
         delay_ff  <= delay_in;
         period_ff <= period_in;
      end
   end

   // Serialise the events of each item onto the result channel
   hrke_event_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire),
      .job      (job),
      .can_load (can_load),
      .rsp      (rsp_ch)
   );

endmodule

// ===== sim/tb_hid_report_to_key_events.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hid_report_to_key_events: self-checking bench for the HID key event block
// Feeds keyboard reports and millisecond ticks through the request channel.
// A local keyboard model predicts every press, release and repeat event, and
// the monitor compares each response transfer against the oldest prediction.
// The run covers a directed part, then random report sequences under three
// repeat settings and three idling mixes.
// ----------------------------------------------------------------------------
module tb_hid_report_to_key_events;
   import hrke_pkg::*;

   // One request item: a report (modifiers and six slots) or a tick
   typedef struct packed {
      logic        cmd;
      logic [7:0]  mods;
      key_set_type keys;
   } key_item_type;

   // One key event as it leaves the response channel
   typedef struct packed {
      logic [7:0] code;
      logic       pressed;
      logic       last;
   } key_event_type;

   logic clock;
   logic reset;

   hrke_req_if req_ch ();
   hrke_rsp_if rsp_ch ();
   hrke_csr_if csr_ch ();

   hid_report_to_key_events DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Items waiting to be offered, and events waiting to be seen
   key_item_type  pending_items[$];
   key_event_type expected_key_events[$];

   // Keyboard model: repeat settings and the state carried between reports
   logic [15:0] repeat_delay;
   logic [15:0] repeat_period;
   logic [7:0]  last_mods;
   key_set_type last_keys;
   logic [7:0]  held_repeat_key;
   logic [15:0] repeat_countdown;

   // Report generator: the keys and modifiers the "user" is holding
   logic [7:0] held_keys[$];
   logic [7:0] held_mods;

   int  sender_idle_pct;
   int  receiver_idle_pct;
   int  rsp_hold_cycles;
   int  mismatch_count;
   bit  req_taken;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Keyboard model
   // -------------------------------------------------------------------------
   function automatic bit key_listed(key_set_type keys, logic [7:0] code);
      for (int s = 0; s < KEY_SLOTS; s++)
         if (keys[s] == code)
            return 1'b1;
      return 1'b0;
   endfunction

   // Work out the events that one accepted item causes and queue them
   function automatic void predict_key_events(key_item_type item);
      key_event_type events[$];
      logic [7:0] changed;
      logic [2:0] bit_idx;
      if (item.cmd == CMD_TICK) begin
         // Ticks only matter while a repeat key is live
         if (held_repeat_key != 8'h00) begin
            if (repeat_countdown != 16'h0000)
               repeat_countdown = repeat_countdown - 16'd1;
            if (repeat_countdown == 16'h0000) begin
               events.push_back('{code: held_repeat_key, pressed: 1'b1, last: 1'b0});
               repeat_countdown = repeat_period;
            end
         end
      end else begin
         // Modifier changes first, in the fixed emission order
         changed = item.mods ^ last_mods;
         for (int m = 0; m < NUM_MODS; m++) begin
            bit_idx = MOD_ORDER[m];
            if (changed[bit_idx])
               events.push_back('{code: 8'(MOD_USAGE_BASE + bit_idx),
                                  pressed: item.mods[bit_idx], last: 1'b0});
         end
         // New keys in slot order; the last one becomes the repeat key
         for (int s = 0; s < KEY_SLOTS; s++) begin
            if (item.keys[s] != 8'h00 && !key_listed(last_keys, item.keys[s])) begin
               events.push_back('{code: item.keys[s], pressed: 1'b1, last: 1'b0});
               held_repeat_key  = item.keys[s];
               repeat_countdown = repeat_delay;
            end
         end
         // Vanished keys in previous-slot order; dropping the repeat key stops it
         for (int s = 0; s < KEY_SLOTS; s++) begin
            if (last_keys[s] != 8'h00 && !key_listed(item.keys, last_keys[s])) begin
               events.push_back('{code: last_keys[s], pressed: 1'b0, last: 1'b0});
               if (last_keys[s] == held_repeat_key)
                  held_repeat_key = 8'h00;
            end
         end
         last_mods = item.mods;
         last_keys = item.keys;
      end
      if (events.size() > 0)
         events[events.size() - 1].last = 1'b1;
      foreach (events[e])
         expected_key_events.push_back(events[e]);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_report(input logic [7:0] mods, input logic [7:0] k0,
                               input logic [7:0] k1, input logic [7:0] k2,
                               input logic [7:0] k3, input logic [7:0] k4,
                               input logic [7:0] k5);
      key_item_type item;
      item.cmd  = CMD_REPORT;
      item.mods = mods;
      item.keys = {k5, k4, k3, k2, k1, k0};
      pending_items.push_back(item);
   endtask

   // Tick payload is ignored by the block, so fill it with whatever is given
   task automatic queue_tick(input logic [7:0] junk);
      key_item_type item;
      item.cmd  = CMD_TICK;
      item.mods = junk;
      item.keys = {KEY_SLOTS{junk}};
      pending_items.push_back(item);
   endtask

   // Random item: mostly ticks and plausible typing, some raw noise
   function automatic key_item_type random_key_item();
      key_item_type item;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         item.cmd  = CMD_TICK;
         item.mods = 8'($urandom());
         for (int s = 0; s < KEY_SLOTS; s++)
            item.keys[s] = 8'($urandom());
      end else if (pick < 88) begin
         // Evolve the held set by one keyboard action, keys from a small pool
         case ($urandom_range(4))
            0, 1: begin
               if (held_keys.size() < KEY_SLOTS)
                  held_keys.push_back(8'(8'h04 + $urandom_range(7)));
            end
            2: begin
               if (held_keys.size() > 0)
                  held_keys.delete($urandom_range(held_keys.size() - 1));
            end
            3: begin
               held_mods = held_mods ^ 8'(1 << $urandom_range(7));
            end
            default: begin
               held_keys.delete();
               repeat ($urandom_range(1, 3))
                  held_keys.push_back(8'(8'h04 + $urandom_range(7)));
            end
         endcase
         item.cmd  = CMD_REPORT;
         item.mods = held_mods;
         item.keys = '0;
         foreach (held_keys[h])
            item.keys[h] = held_keys[h];
      end else begin
         // Noise report: any usage in any slot, gaps anywhere
         item.cmd  = CMD_REPORT;
         item.mods = 8'($urandom());
         for (int s = 0; s < KEY_SLOTS; s++)
            item.keys[s] = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      end
      return item;
   endfunction

   task automatic add_random_items(input int count);
      repeat (count)
         pending_items.push_back(random_key_item());
   endtask

   // Hold until every item is taken and every event seen, then let the block settle
   task automatic wait_quiet();
      while (pending_items.size() != 0 || req_ch.valid || expected_key_events.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Write one repeat register and mirror it into the model on the transfer
   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [15:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= index;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      if (index == REG_REPEAT_DELAY)
         repeat_delay = value;
      else
         repeat_period = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Driver: offer the next pending item on the falling edge; hold an item
   // until its transfer, and idle at random between items
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      key_item_type next_item;
      if (!reset && (!req_ch.valid || req_taken)) begin
         req_taken = 1'b0;
         if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_item = pending_items.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.cmd           <= next_item.cmd;
            req_ch.modifier_bits <= next_item.mods;
            req_ch.slot_0        <= next_item.keys[0];
            req_ch.slot_1        <= next_item.keys[1];
            req_ch.slot_2        <= next_item.keys[2];
            req_ch.slot_3        <= next_item.keys[3];
            req_ch.slot_4        <= next_item.keys[4];
            req_ch.slot_5        <= next_item.keys[5];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure: a long hold when asked, else random stalls
   always @(negedge clock) begin : receiver
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: on the rising edge, check any response transfer first, then
   // feed any request transfer into the model
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      key_event_type want;
      key_item_type  taken_item;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_key_events.size() == 0) begin
               $error("unexpected key event: key_code %02h pressed %0b last %0b",
                      rsp_ch.key_code, rsp_ch.pressed, rsp_ch.last);
               mismatch_count++;
            end else begin
               want = expected_key_events.pop_front();
               if (rsp_ch.key_code !== want.code) begin
                  $error("key_code: expected %02h, got %02h", want.code, rsp_ch.key_code);
                  mismatch_count++;
               end
               if (rsp_ch.pressed !== want.pressed) begin
                  $error("pressed: expected %0b, got %0b", want.pressed, rsp_ch.pressed);
                  mismatch_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken_item.cmd     = req_ch.cmd;
            taken_item.mods    = req_ch.modifier_bits;
            taken_item.keys[0] = req_ch.slot_0;
            taken_item.keys[1] = req_ch.slot_1;
            taken_item.keys[2] = req_ch.slot_2;
            taken_item.keys[3] = req_ch.slot_3;
            taken_item.keys[4] = req_ch.slot_4;
            taken_item.keys[5] = req_ch.slot_5;
            predict_key_events(taken_item);
            req_taken = 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      // Known values on every input from time zero
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = CMD_REPORT;
      req_ch.modifier_bits = 8'h00;
      req_ch.slot_0        = 8'h00;
      req_ch.slot_1        = 8'h00;
      req_ch.slot_2        = 8'h00;
      req_ch.slot_3        = 8'h00;
      req_ch.slot_4        = 8'h00;
      req_ch.slot_5        = 8'h00;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.addr          = REG_REPEAT_DELAY;
      csr_ch.data          = 16'h0000;

      // Model starts from the reset state of the block
      repeat_delay     = 16'd500;
      repeat_period    = 16'd100;
      last_mods        = 8'h00;
      last_keys        = '0;
      held_repeat_key  = 8'h00;
      repeat_countdown = 16'h0000;
      held_mods        = 8'h00;
      req_taken        = 1'b0;
      mismatch_count   = 0;
      rsp_hold_cycles  = 0;

      // First idling mix: sender idles a little, receiver a lot
      sender_idle_pct   = 14;
      receiver_idle_pct = 49;

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // --- Directed part, reset repeat settings ---
      queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // no change
      queue_tick(8'hFF);                                              // no repeat key
      queue_report(8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06); // all mods down
      queue_report(8'h00, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C); // widest diff
      queue_report(8'h00, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C); // no change
      queue_report(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00); // duplicate press
      queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF); // key moves slot
      queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // repeat key up
      queue_tick(8'h00);
      wait_quiet();

      // Zero delay and zero period: a repeat on every tick
      write_register(REG_REPEAT_DELAY, 16'd0);
      write_register(REG_REPEAT_PERIOD, 16'd0);
      queue_report(8'h00, 8'h2C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_tick(8'h00);
      queue_tick(8'h55);
      queue_tick(8'hAA);
      queue_report(8'h00, 8'h2C, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00); // new repeat key
      queue_report(8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // other key up
      queue_tick(8'h00);
      queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_tick(8'h00);
      wait_quiet();

      write_register(REG_REPEAT_DELAY, 16'd2);
      write_register(REG_REPEAT_PERIOD, 16'd1);
      queue_report(8'h81, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      repeat (3) queue_tick(8'h00);
      queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_quiet();

      // --- Random part, first mix; sender pauses mid-way until all is seen ---
      write_register(REG_REPEAT_DELAY, 16'd3);
      write_register(REG_REPEAT_PERIOD, 16'd2);
      add_random_items(35);
      wait_quiet();
      add_random_items(30);
      wait_quiet();

      // --- Second mix: receiver idles a little, sender a lot; top settings ---
      sender_idle_pct   = 49;
      receiver_idle_pct = 14;
      write_register(REG_REPEAT_DELAY, 16'hFFFF);
      write_register(REG_REPEAT_PERIOD, 16'hFFFF);
      add_random_items(65);
      wait_quiet();

      // --- No idling; open with a long receiver hold so the block backs up ---
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_register(REG_REPEAT_DELAY, 16'd1);
      write_register(REG_REPEAT_PERIOD, 16'd1);
      rsp_hold_cycles = 400;
      add_random_items(70);
      wait_quiet();

      if (mismatch_count == 0)
         $display("tb_hid_report_to_key_events: done, clean");
      else
         $display("tb_hid_report_to_key_events: done, errors");
      $finish;
   end

   // Watchdog: well past the slowest correct run
   initial begin
      #(2_000_000);
      $display("tb_hid_report_to_key_events: done, errors");
      $finish;
   end

endmodule
